### hdl/coap_request_header_parser_unit_macros.svh
// assertion macros for the coap request header parser
`ifndef COAP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH
`define COAP_REQUEST_HEADER_PARSER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/coap_hp_pkg.sv
// shared types and codes for the coap request header parser
package coap_hp_pkg;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [1:0] RESET_VERSION = 2'd1;
  localparam logic [3:0] URI_PATH_OPT  = 4'd11;
  localparam logic [7:0] PATH_SLASH    = 8'h2f;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_packet;
  } rx_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  msg_type;
    logic [3:0]  option_total;
    logic [7:0]  req_code;
    logic [15:0] msg_id;
    logic [7:0]  data_byte;
    logic        last_of_packet;
  } result_t;

  typedef struct packed {
    logic [1:0] expected_version;
  } cfg_beat_t;

endpackage

### hdl/coap_hp_if.sv
// valid/ready channel carrying one beat of a given payload type
interface coap_hp_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/coap_request_header_parser_unit.sv
// results are registered in the result queue before they reach the output
// throughput: one input beat per cycle while ready is high; a beat may yield up to
//   two results, which drain one per cycle from a three-entry result queue while
//   res.ready is high; ready drops while two or more results are queued
// synchronous reset returns the parser to byte zero, empties the queue and sets
//   the expected version to 1
module coap_request_header_parser_unit
  import coap_hp_pkg::*;
(
  input logic clk,
  input logic rst,
  coap_hp_if.sink   rx,
  coap_hp_if.sink   cfg,
  coap_hp_if.source res
);
  `include "coap_request_header_parser_unit_macros.svh"

  localparam logic [2:0] PH_B0  = 3'd0;
  localparam logic [2:0] PH_B1  = 3'd1;
  localparam logic [2:0] PH_B2  = 3'd2;
  localparam logic [2:0] PH_B3  = 3'd3;
  localparam logic [2:0] PH_OPT = 3'd4;
  localparam logic [2:0] PH_SEG = 3'd5;
  localparam logic [2:0] PH_PAY = 3'd6;

  logic [1:0] expected_version;
  logic [2:0] phase, phase_next;
  logic [3:0] options_left, options_left_next;
  logic [3:0] segment_left, segment_left_next;
  logic [3:0] prior_option, prior_option_next;
  logic       fault_seen, fault_seen_next;
  logic [1:0] held_type, held_type_next;
  logic [7:0] held_code, held_code_next;
  logic [7:0] held_id_high, held_id_high_next;
  logic [3:0] held_count, held_count_next;

  result_t    q [3];
  result_t    q_next [3];
  logic [1:0] cnt, cnt_next, cnt_base;

  logic       accept, pop;
  logic [7:0] b;
  logic       eop;
  result_t    step_res, end_res, res_a, res_b;
  logic       step_valid;
  logic [1:0] n_res;
  logic [3:0] delta;
  logic [3:0] seg_dec;

  assign accept    = rx.valid && rx.ready;
  assign pop       = res.valid && res.ready;
  assign rx.ready  = (cnt < 2'd2);
  assign cfg.ready = 1'b1;
  assign res.valid = (cnt != 2'd0);
  assign res.data  = q[0];
  assign b         = rx.data.in_byte;
  assign eop       = rx.data.end_of_packet;

  // per-byte parse step
  always_comb begin
    phase_next        = phase;
    options_left_next = options_left;
    segment_left_next = segment_left;
    prior_option_next = prior_option;
    fault_seen_next   = fault_seen;
    held_type_next    = held_type;
    held_code_next    = held_code;
    held_id_high_next = held_id_high;
    held_count_next   = held_count;
    step_res          = '0;
    step_valid        = 1'b0;
    delta             = b[7:4];
    seg_dec           = segment_left - 4'd1;
    if (delta == 4'd0 && prior_option != 4'd0) begin
      delta = prior_option;
    end
    if (!fault_seen) begin
      case (phase)
        PH_B0: begin
          if (b[7:6] != expected_version) begin
            fault_seen_next = 1'b1;
          end else begin
            held_type_next  = b[5:4];
            held_count_next = b[3:0];
            phase_next      = PH_B1;
          end
        end
        PH_B1: begin
          held_code_next = b;
          phase_next     = PH_B2;
        end
        PH_B2: begin
          held_id_high_next = b;
          phase_next        = PH_B3;
        end
        PH_B3: begin
          step_valid            = 1'b1;
          step_res.kind         = KIND_HEADER;
          step_res.msg_type     = held_type;
          step_res.option_total = held_count;
          step_res.req_code     = held_code;
          step_res.msg_id       = {held_id_high, b};
          options_left_next     = held_count;
          prior_option_next     = 4'd0;
          if (held_count == 4'd0) begin
            fault_seen_next = 1'b1;
          end else begin
            phase_next = PH_OPT;
          end
        end
        PH_OPT: begin
          if (delta != URI_PATH_OPT) begin
            fault_seen_next = 1'b1;
          end else begin
            prior_option_next  = delta;
            segment_left_next  = b[3:0];
            options_left_next  = options_left - 4'd1;
            step_valid         = 1'b1;
            step_res.kind      = KIND_PATH;
            step_res.data_byte = PATH_SLASH;
            if (b[3:0] == 4'd0) begin
              phase_next = (options_left_next == 4'd0) ? PH_PAY : PH_OPT;
            end else begin
              phase_next = PH_SEG;
            end
          end
        end
        PH_SEG: begin
          step_valid         = 1'b1;
          step_res.kind      = KIND_PATH;
          step_res.data_byte = b;
          segment_left_next  = seg_dec;
          if (seg_dec == 4'd0) begin
            phase_next = (options_left == 4'd0) ? PH_PAY : PH_OPT;
          end
        end
        default: begin
          step_valid         = 1'b1;
          step_res.kind      = KIND_PAYLOAD;
          step_res.data_byte = b;
        end
      endcase
    end

    end_res                = '0;
    end_res.kind           = (!fault_seen_next && phase_next == PH_PAY) ? KIND_DONE
                                                                        : KIND_ERROR;
    end_res.last_of_packet = 1'b1;

    if (eop) begin
      phase_next        = PH_B0;
      options_left_next = 4'd0;
      segment_left_next = 4'd0;
      prior_option_next = 4'd0;
      fault_seen_next   = 1'b0;
      held_type_next    = 2'd0;
      held_code_next    = 8'd0;
      held_id_high_next = 8'd0;
      held_count_next   = 4'd0;
    end

    res_a = step_valid ? step_res : end_res;
    res_b = end_res;
    n_res = {1'b0, step_valid} + {1'b0, eop};
  end

  // result queue: entry 0 is the output beat
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_next[i] = q[i];
    end
    cnt_base = cnt;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
      cnt_base  = cnt - 2'd1;
    end
    cnt_next = cnt_base;
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (n_res != 2'd0 && 2'(i) == cnt_base) begin
          q_next[i] = res_a;
        end
        if (n_res == 2'd2 && 2'(i) == cnt_base + 2'd1) begin
          q_next[i] = res_b;
        end
      end
      cnt_next = cnt_base + n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= RESET_VERSION;
      phase            <= PH_B0;
      options_left     <= 4'd0;
      segment_left     <= 4'd0;
      prior_option     <= 4'd0;
      fault_seen       <= 1'b0;
      held_type        <= 2'd0;
      held_code        <= 8'd0;
      held_id_high     <= 8'd0;
      held_count       <= 4'd0;
      cnt              <= 2'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        expected_version <= cfg.data.expected_version;
      end
      if (accept) begin
        phase        <= phase_next;
        options_left <= options_left_next;
        segment_left <= segment_left_next;
        prior_option <= prior_option_next;
        fault_seen   <= fault_seen_next;
        held_type    <= held_type_next;
        held_code    <= held_code_next;
        held_id_high <= held_id_high_next;
        held_count   <= held_count_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
  end

  `CHP_ASSERT_NEXT(a_eop_restarts, accept && eop, phase == PH_B0 && !fault_seen, "parser not reset after end of packet")
  `CHP_ASSERT_SAME(a_last_is_final, res.valid && res.data.last_of_packet, res.data.kind == KIND_DONE || res.data.kind == KIND_ERROR, "last beat is not done or error")
  `CHP_ASSERT_NEXT(a_queue_grows, accept && !pop && n_res == 2'd2, cnt == $past(cnt) + 2'd2, "result queue lost a beat")

endmodule
